### hdl/wpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint path interpolator package
// shared payload types, controller states and command/status structs
// ----------------------------------------------------------------------------
package wpi_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned StepWidth  = 21;

   typedef struct packed {
      logic signed [CoordWidth-1:0] waypoint_x;
      logic signed [CoordWidth-1:0] waypoint_y;
      logic signed [CoordWidth-1:0] waypoint_z;
      logic                         path_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] point_z;
      logic                         segment_end;
      logic                         steps_clipped;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT,
      ST_STEPDIV,
      ST_POINT,
      ST_PDIV,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture accepted waypoint and deltas
      logic store_only; // path start or no previous waypoint: just latch waypoint
      logic sq_step;    // accumulate one squared delta
      logic sqrt_init;
      logic sqrt_step;
      logic sdiv_init;
      logic sdiv_step;
      logic n_load;     // latch step count and clip flag
      logic pnt_init;   // start point j, load products
      logic pdiv_step;
      logic out_load;   // capture point into output register
      logic next_j;
      logic commit;     // new waypoint becomes previous
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic new_seg;    // accepted item produces a segment
      logic big;        // delta too large, skip root
      logic sq_done;
      logic sqrt_done;
      logic sdiv_done;
      logic pdiv_done;
      logic last_point;
   } status_type;

endpackage

### hdl/wpi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpi datapath
// deltas, sum of squares, bit-serial root, step divider and point dividers
// ----------------------------------------------------------------------------
module wpi_datapath #(
   parameter int unsigned MAX_SEGMENT_STEPS = 63,
   parameter int unsigned COORD_FRAC_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [wpi_pkg::StepWidth-1:0] csr_write_data,
   input  wpi_pkg::req_payload_type req_payload,
   input  wpi_pkg::cmd_type         cmd,
   output wpi_pkg::status_type      status,
   output wpi_pkg::rsp_payload_type rsp_payload
);
   localparam int unsigned SW = wpi_pkg::StepWidth;
   localparam int unsigned NW = $clog2(MAX_SEGMENT_STEPS + 1);
   localparam longint unsigned StepResetRaw = ((64'd1 << COORD_FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [SW-1:0] StepReset =
      (StepResetRaw > 64'h1FFFFF) ? {SW{1'b1}} : StepResetRaw[SW-1:0];
   localparam logic [NW-1:0] MaxSteps = NW'(MAX_SEGMENT_STEPS);
   // product j*delta: |j|<=63, |delta|<2^33 -> 40 bits
   localparam int unsigned PW = 40;

   logic [SW-1:0] step_ff;
   logic signed [31:0] prev_ff [3];
   logic signed [31:0] new_ff [3];
   logic have_prev_ff;
   logic signed [32:0] d_ff [3];
   logic [1:0] sq_idx_ff;
   // sum of squares in a 58-bit frame, consumed two bits a root step
   logic [57:0] sum_ff;
   logic big_ff;
   // root
   logic [56:0] rem_ff;
   logic [28:0] root_ff;
   logic [4:0] rcnt_ff;
   // step divider: quotient of 29-bit root by step
   logic [28:0] squo_ff;
   logic [SW:0] srem_ff;
   logic [4:0] scnt_ff;
   logic [NW-1:0] n_ff;
   logic clip_ff;
   logic [NW-1:0] j_ff;
   // point dividers
   logic [PW-1:0] num_ff [3];
   logic neg_ff [3];
   logic [PW-1:0] q_ff [3];
   logic [NW:0] prem_ff [3];
   logic [5:0] pcnt_ff;
   wpi_pkg::rsp_payload_type out_ff;

   logic signed [32:0] din [3];
   logic [32:0] dmag;
   logic [53:0] sq;
   logic [SW-1:0] step_eff;
   logic [SW:0] srem_sh;
   logic [NW-1:0] n_calc;
   logic [58:0] prem;
   logic [58:0] rtry;

   assign din[0] = 33'(req_payload.waypoint_x) - 33'(prev_ff[0]);
   assign din[1] = 33'(req_payload.waypoint_y) - 33'(prev_ff[1]);
   assign din[2] = 33'(req_payload.waypoint_z) - 33'(prev_ff[2]);
   assign dmag  = d_ff[sq_idx_ff][32] ? 33'(-d_ff[sq_idx_ff]) : d_ff[sq_idx_ff];
   assign sq    = 54'(dmag[26:0]) * 54'(dmag[26:0]);
   assign step_eff = (step_ff == '0) ? SW'(1) : step_ff;
   assign srem_sh = {srem_ff[SW-1:0], squo_ff[28]};
   assign n_calc = (squo_ff > 29'(MAX_SEGMENT_STEPS)) ? MaxSteps :
                   (squo_ff == '0) ? NW'(1) : squo_ff[NW-1:0];

   // bit-pair root: remainder register holds partial remainder, sum shifts out top
   assign prem = {rem_ff, sum_ff[57:56]};
   assign rtry = 59'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= StepReset;
         have_prev_ff <= 1'b0;
         for (int k = 0; k < 3; k++) prev_ff[k] <= '0;
      end else begin
         if (csr_write_enable) step_ff <= csr_write_data;
         if (cmd.load) begin
            new_ff[0] <= req_payload.waypoint_x;
            new_ff[1] <= req_payload.waypoint_y;
            new_ff[2] <= req_payload.waypoint_z;
            for (int k = 0; k < 3; k++) d_ff[k] <= din[k];
            big_ff    <= 1'b0;
            sum_ff    <= '0;
            sq_idx_ff <= '0;
            j_ff      <= '0;
            // saturated count unless the root path replaces it
            n_ff      <= MaxSteps;
            clip_ff   <= 1'b1;
         end
         if (cmd.store_only) begin
            prev_ff[0]   <= req_payload.waypoint_x;
            prev_ff[1]   <= req_payload.waypoint_y;
            prev_ff[2]   <= req_payload.waypoint_z;
            have_prev_ff <= 1'b1;
         end
         if (cmd.sq_step) begin
            if (dmag[32:27] != '0) big_ff <= 1'b1;
            sum_ff    <= sum_ff + 58'(sq);
            sq_idx_ff <= sq_idx_ff + 2'd1;
         end
         if (cmd.sqrt_init) begin
            rem_ff  <= '0;
            root_ff <= '0;
            rcnt_ff <= '0;
         end
         if (cmd.sqrt_step) begin
            if (prem >= rtry) begin
               rem_ff  <= 57'(prem - rtry);
               root_ff <= {root_ff[27:0], 1'b1};
            end else begin
               rem_ff  <= prem[56:0];
               root_ff <= {root_ff[27:0], 1'b0};
            end
            sum_ff  <= {sum_ff[55:0], 2'b00};
            rcnt_ff <= rcnt_ff + 5'd1;
         end
         if (cmd.sdiv_init) begin
            squo_ff <= root_ff;
            srem_ff <= '0;
            scnt_ff <= '0;
         end
         if (cmd.sdiv_step) begin
            if (srem_sh >= {1'b0, step_eff}) begin
               srem_ff <= srem_sh - {1'b0, step_eff};
               squo_ff <= {squo_ff[27:0], 1'b1};
            end else begin
               srem_ff <= srem_sh;
               squo_ff <= {squo_ff[27:0], 1'b0};
            end
            scnt_ff <= scnt_ff + 5'd1;
         end
         // n is fixed once the step division ends
         if (cmd.n_load) begin
            n_ff    <= n_calc;
            clip_ff <= (squo_ff > 29'(MAX_SEGMENT_STEPS));
         end
         if (cmd.pnt_init) begin
            for (int k = 0; k < 3; k++) begin
               logic signed [PW-1:0] p;
               p = PW'($signed({1'b0, j_ff})) * PW'(d_ff[k]);
               neg_ff[k]  <= p[PW-1];
               num_ff[k]  <= p[PW-1] ? PW'(-p) : PW'(p);
               q_ff[k]    <= '0;
               prem_ff[k] <= '0;
            end
            pcnt_ff <= '0;
         end
         if (cmd.pdiv_step) begin
            for (int k = 0; k < 3; k++) begin
               logic [NW:0] r;
               r = {prem_ff[k][NW-1:0], num_ff[k][PW-1]};
               num_ff[k] <= {num_ff[k][PW-2:0], 1'b0};
               if (r >= {1'b0, n_ff}) begin
                  prem_ff[k] <= r - {1'b0, n_ff};
                  q_ff[k]    <= {q_ff[k][PW-2:0], 1'b1};
               end else begin
                  prem_ff[k] <= r;
                  q_ff[k]    <= {q_ff[k][PW-2:0], 1'b0};
               end
            end
            pcnt_ff <= pcnt_ff + 6'd1;
         end
         if (cmd.next_j) j_ff <= j_ff + NW'(1);
         if (cmd.commit) begin
            for (int k = 0; k < 3; k++) prev_ff[k] <= new_ff[k];
         end
      end
   end

   logic signed [31:0] pt [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pt[k] = prev_ff[k] + (neg_ff[k] ? 32'(-q_ff[k]) : 32'(q_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.point_x       <= pt[0];
         out_ff.point_y       <= pt[1];
         out_ff.point_z       <= pt[2];
         out_ff.segment_end   <= (j_ff == n_ff);
         out_ff.steps_clipped <= clip_ff;
      end
   end

   assign rsp_payload = out_ff;
   assign status.new_seg    = have_prev_ff && !req_payload.path_start;
   assign status.big        = big_ff;
   assign status.sq_done    = (sq_idx_ff == 2'd3);
   assign status.sqrt_done  = (rcnt_ff == 5'd29);
   assign status.sdiv_done  = (scnt_ff == 5'd29);
   assign status.pdiv_done  = (pcnt_ff == 6'(PW));
   assign status.last_point = (j_ff == n_ff);

`ifndef SYNTHESIS
   a_sum_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_init && !big_ff |-> sum_ff[57:56] == 2'b00) else $error("sum");
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> n_ff != '0 && n_ff <= MaxSteps) else $error("n out of range");
   a_j_range: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> j_ff <= n_ff) else $error("j past n");
`endif
endmodule

### hdl/wpi_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpi controller
// sequences square, root, step division and per-point divisions
// ----------------------------------------------------------------------------
module wpi_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wpi_pkg::status_type status,
   output wpi_pkg::cmd_type    cmd
);
   wpi_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         wpi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.new_seg) begin
                  cmd.load = 1'b1;
                  state_in = wpi_pkg::ST_SQUARE;
               end else begin
                  cmd.store_only = 1'b1;
               end
            end
         end
         wpi_pkg::ST_SQUARE: begin
            if (status.sq_done) begin
               cmd.sqrt_init = 1'b1;
               state_in = status.big ? wpi_pkg::ST_POINT : wpi_pkg::ST_SQRT;
            end else begin
               cmd.sq_step = 1'b1;
            end
         end
         wpi_pkg::ST_SQRT: begin
            if (status.sqrt_done) begin
               cmd.sdiv_init = 1'b1;
               state_in = wpi_pkg::ST_STEPDIV;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         wpi_pkg::ST_STEPDIV: begin
            if (status.sdiv_done) begin
               cmd.n_load = 1'b1;
               state_in = wpi_pkg::ST_POINT;
            end else begin
               cmd.sdiv_step = 1'b1;
            end
         end
         wpi_pkg::ST_POINT: begin
            cmd.pnt_init = 1'b1;
            state_in = wpi_pkg::ST_PDIV;
         end
         wpi_pkg::ST_PDIV: begin
            if (status.pdiv_done) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.out_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (status.last_point) begin
                     cmd.commit = 1'b1;
                     state_in = wpi_pkg::ST_OUT;
                  end else begin
                     cmd.next_j = 1'b1;
                     state_in = wpi_pkg::ST_POINT;
                  end
               end
            end else begin
               cmd.pdiv_step = 1'b1;
            end
         end
         wpi_pkg::ST_OUT: begin
            state_in = wpi_pkg::ST_IDLE;
         end
         default: state_in = wpi_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != wpi_pkg::ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready)) else $error("output overwritten");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sq_step, cmd.sqrt_step, cmd.sdiv_step, cmd.pdiv_step}))
      else $error("unit overlap");
`endif
endmodule

### hdl/waypoint_path_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint path interpolator
// turns a waypoint stream into evenly spaced 3-d path points
// ----------------------------------------------------------------------------
// One waypoint transaction at a time. A path-start waypoint, or the first
// waypoint after reset, is stored with no output. Otherwise the block takes
// the transaction, squares the three deltas, takes a bit-serial square root
// and divides by step_size bit-serially; root and step division are skipped
// when a delta is 2^27 or more. Then for each of the n+1 points it loads the
// products, runs three parallel 40-bit bit-serial dividers and hands the
// point to the output, where an output stall can hold it, and ends with a
// settling state (ST_OUT). Points leave through a one-entry output register.
module waypoint_path_interpolator #(
   parameter int unsigned MAX_SEGMENT_STEPS = 63,
   parameter int unsigned COORD_FRAC_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [wpi_pkg::StepWidth-1:0]  csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  wpi_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output wpi_pkg::rsp_payload_type       rsp_payload
);
   // command / status link between controller and datapath
   wpi_pkg::cmd_type    cmd;
   wpi_pkg::status_type status;

   wpi_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wpi_datapath #(
      .MAX_SEGMENT_STEPS (MAX_SEGMENT_STEPS),
      .COORD_FRAC_BITS   (COORD_FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .cmd              (cmd),
      .status           (status),
      .rsp_payload      (rsp_payload)
   );
endmodule

### tb/tb_waypoint_path_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint path interpolator testbench
// drives waypoint transactions under random idling and output stalls, and
// predicts every interpolated point, clip flag and segment end locally
// ----------------------------------------------------------------------------
module tb_waypoint_path_interpolator;

   localparam int unsigned CW         = wpi_pkg::CoordWidth;
   localparam int unsigned SW         = wpi_pkg::StepWidth;
   localparam int unsigned MaxSteps   = 63;
   localparam longint      BigDelta   = 64'sd1 << 27;
   localparam int unsigned StepReset  = 6554;
   localparam int unsigned DrainWait  = 200;
   localparam int unsigned StallLimit = 20000;
   localparam int unsigned StepList [6] = '{1, 0, 1048576, 2097151, 300, 65536};

   // ---------------------------------------------------------------------------
   // expected point store and segment predictor
   // ---------------------------------------------------------------------------
   class path_scoreboard;
      bit [SW-1:0] spacing;
      logic signed [CW-1:0] last_x, last_y, last_z;
      bit have_last;
      wpi_pkg::rsp_payload_type expected_points[$];
      int errors, points_seen, segments, clipped_segments, waypoints;

      function new();
         spacing = StepReset;
         last_x = '0;
         last_y = '0;
         last_z = '0;
         have_last = 1'b0;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function longint unsigned int_root(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // one accepted waypoint: store it, or predict the whole segment
      function void note_waypoint(wpi_pkg::req_payload_type w);
         longint dx, dy, dz, ax, ay, az, nsteps, divisor;
         bit clip;
         wpi_pkg::rsp_payload_type p;
         waypoints++;
         if (w.path_start || !have_last) begin
            last_x = w.waypoint_x;
            last_y = w.waypoint_y;
            last_z = w.waypoint_z;
            have_last = 1'b1;
            return;
         end
         dx = longint'(w.waypoint_x) - longint'(last_x);
         dy = longint'(w.waypoint_y) - longint'(last_y);
         dz = longint'(w.waypoint_z) - longint'(last_z);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         az = dz < 0 ? -dz : dz;
         divisor = (spacing == 0) ? 1 : longint'(spacing);
         if (ax >= BigDelta || ay >= BigDelta || az >= BigDelta)
            nsteps = MaxSteps + 1;
         else
            nsteps = longint'(int_root(ax * ax + ay * ay + az * az)) / divisor;
         clip = 1'b0;
         if (nsteps < 1) nsteps = 1;
         if (nsteps > MaxSteps) begin
            nsteps = MaxSteps;
            clip = 1'b1;
         end
         segments++;
         if (clip) clipped_segments++;
         for (longint j = 0; j <= nsteps; j++) begin
            p.point_x       = CW'(longint'(last_x) + (j * dx) / nsteps);
            p.point_y       = CW'(longint'(last_y) + (j * dy) / nsteps);
            p.point_z       = CW'(longint'(last_z) + (j * dz) / nsteps);
            p.segment_end   = (j == nsteps);
            p.steps_clipped = clip;
            expected_points = {expected_points, p};
         end
         last_x = w.waypoint_x;
         last_y = w.waypoint_y;
         last_z = w.waypoint_z;
      endfunction

      task check_point(wpi_pkg::rsp_payload_type got);
         wpi_pkg::rsp_payload_type want;
         points_seen++;
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected point %0d,%0d,%0d",
                                      got.point_x, got.point_y, got.point_z));
            return;
         end
         want = expected_points.pop_front();
         if (got.point_x !== want.point_x)
            report_mismatch($sformatf("point_x %0d, want %0d", got.point_x, want.point_x));
         if (got.point_y !== want.point_y)
            report_mismatch($sformatf("point_y %0d, want %0d", got.point_y, want.point_y));
         if (got.point_z !== want.point_z)
            report_mismatch($sformatf("point_z %0d, want %0d", got.point_z, want.point_z));
         if (got.segment_end !== want.segment_end)
            report_mismatch($sformatf("segment_end %b, want %b",
                                      got.segment_end, want.segment_end));
         if (got.steps_clipped !== want.steps_clipped)
            report_mismatch($sformatf("steps_clipped %b, want %b",
                                      got.steps_clipped, want.steps_clipped));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [SW-1:0] csr_write_data;
   logic req_valid;
   logic req_ready;
   wpi_pkg::req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   wpi_pkg::rsp_payload_type rsp_payload;

   path_scoreboard sb;
   bit calm;          // no idling on either side while set
   int idle_cycles;   // cycles with no transaction on either channel
   logic signed [CW-1:0] cur_x, cur_y, cur_z;  // last waypoint sent

   waypoint_path_interpolator i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sampled before the block's own updates at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_waypoint(req_payload);
         if (rsp_valid && rsp_ready) sb.check_point(rsp_payload);
      end
   end

   // output side stalls with a chance of about 16 percent unless calm
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 16);
   end

   // watchdog: too long without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("watchdog expired with %0d points outstanding",
                  sb.expected_points.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // hold valid until the transaction is accepted; valid stays high after, unless a random idle gap drops it
   task automatic send_waypoint(wpi_pkg::req_payload_type w);
      req_valid <= 1'b1;
      req_payload <= w;
      cur_x = w.waypoint_x;
      cur_y = w.waypoint_y;
      cur_z = w.waypoint_z;
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_coords(int x, int y, int z, bit start);
      wpi_pkg::req_payload_type w;
      w.waypoint_x = x;
      w.waypoint_y = y;
      w.waypoint_z = z;
      w.path_start = start;
      send_waypoint(w);
   endtask

   // wait for every outstanding point, then for the block to settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_step(bit [SW-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.spacing = value;
   endtask

   function automatic int signed_offset(int unsigned span);
      int unsigned m;
      m = $urandom_range(span);
      return $urandom_range(1) ? -int'(m) : int'(m);
   endfunction

   // mostly well-formed path moves of a few steps, some noise and restarts
   task automatic send_random(int unsigned step);
      int unsigned eff, span, r;
      eff = (step == 0) ? 1 : step;
      r = $urandom_range(99);
      if (r < 8) begin
         send_coords($urandom, $urandom, $urandom, $urandom_range(1));
      end else if (r < 16) begin
         send_coords(signed_offset(32'h0100_0000), signed_offset(32'h0100_0000),
                     signed_offset(32'h0100_0000), 1'b1);
      end else begin
         span = eff * $urandom_range(0, 8);
         send_coords(cur_x + signed_offset(span), cur_y + signed_offset(span),
                     cur_z + signed_offset(span), 1'b0);
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_payload = '0;
      cur_x = '0;
      cur_y = '0;
      cur_z = '0;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset step size
      send_coords(5 << 16, -3 << 16, 1 << 16, 1'b0);   // no previous waypoint yet
      send_coords(5 << 16, -3 << 16, 1 << 16, 1'b0);   // equal waypoints
      send_coords(6 << 16, -3 << 16, 1 << 16, 1'b0);   // one metre in x
      send_coords(0, 7, -7, 1'b0);
      send_coords(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_coords(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);  // huge
      send_coords(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_coords(0, 0, 0, 1'b1);
      send_coords((1 << 27) - 1, 0, 0, 1'b0);          // root still taken
      send_coords((1 << 27) - 1, 0, -(1 << 27), 1'b0); // skip root at the edge
      send_coords(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b1);
      send_coords(32'h5555_5555 + 3000, 32'haaaa_aaaa - 4000, 32'h5555_5555, 1'b0);
      send_coords(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b1);
      send_coords(32'haaaa_aaaa - 20000, 32'h5555_5555, 32'haaaa_aaaa + 9, 1'b0);
      send_coords(-1, -1, -1, 1'b0);

      // hold the sender until every point is out, then continue
      drain();
      for (int k = 0; k < 20; k++) send_random(StepReset);

      // calm stretch: no idling on either side
      calm = 1'b1;
      for (int k = 0; k < 20; k++) send_random(StepReset);
      calm = 1'b0;

      foreach (StepList[i]) begin
         write_step(SW'(StepList[i]));
         for (int k = 0; k < 33; k++) send_random(StepList[i]);
      end
      write_step(SW'(StepReset));
      for (int k = 0; k < 15; k++) send_random(StepReset);

      drain();
      $display("covered %0d waypoints, %0d segments (%0d clipped), %0d points",
               sb.waypoints, sb.segments, sb.clipped_segments, sb.points_seen);
      $display("step sizes from 0 to 2097151, with idling and output stalls");
      if (sb.errors == 0 && sb.expected_points.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
